@@ src/rsc_pkg.sv @@
// Shared types and constants for the RPN stack calculator.
// Holds the command codes, report kinds, character codes and queue entry type.
// No dependencies.
package rsc_pkg;

  localparam int STACK_DEPTH_DEF   = 128;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int VALUE_W           = 64;

  // Command codes handed from the front end to the execution unit
  localparam logic [2:0] OP_NONE    = 3'd0;
  localparam logic [2:0] OP_ADD     = 3'd1;
  localparam logic [2:0] OP_SUB     = 3'd2;
  localparam logic [2:0] OP_MUL     = 3'd3;
  localparam logic [2:0] OP_DIV     = 3'd4;
  localparam logic [2:0] OP_PRINT   = 3'd5;
  localparam logic [2:0] OP_UNKNOWN = 3'd6;

  // Report kinds
  localparam logic [2:0] KIND_VALUE   = 3'd0;
  localparam logic [2:0] KIND_ZERODIV = 3'd1;
  localparam logic [2:0] KIND_UNKNOWN = 3'd2;
  localparam logic [2:0] KIND_FULL    = 3'd3;
  localparam logic [2:0] KIND_EMPTY   = 3'd4;

  // Characters
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  // One classified item: optional pending-number push, then a command
  typedef struct packed {
    logic               has_push;
    logic [VALUE_W-1:0] push_val;
    logic [2:0]         op;
    logic [7:0]         code;
  } entry_t;

endpackage

@@ src/rsc_front.sv @@
// Front end of the RPN calculator: accepts characters, builds numbers and
// classifies commands into queue entries. Depends on rsc_pkg.
module rsc_front #(
  parameter int FRACTION_BITS = rsc_pkg::FRACTION_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      char_code,
  input  logic            end_of_input,
  input  logic            q_full,
  output logic            q_push,
  output rsc_pkg::entry_t q_entry
);

  localparam int ACC_W = 63 - FRACTION_BITS;

  logic [ACC_W-1:0] acc, acc_next;
  logic             in_number, in_number_next;
  logic             accept;
  logic             is_digit;
  logic [3:0]       digit;
  logic [ACC_W+3:0] scaled;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign is_digit = (char_code >= rsc_pkg::CH_ZERO) && (char_code <= rsc_pkg::CH_NINE);
  assign digit    = 4'(char_code - rsc_pkg::CH_ZERO);

  // acc*10 + digit; anything above the accumulator range saturates
  assign scaled = {acc, 3'b000} + {2'b00, acc, 1'b0} + (ACC_W+4)'(digit);

  // Classification and number building
  always_comb begin
    acc_next       = acc;
    in_number_next = in_number;
    q_entry.has_push = 1'b0;
    q_entry.push_val = 64'(acc) << FRACTION_BITS;
    q_entry.op       = rsc_pkg::OP_NONE;
    q_entry.code     = char_code;
    if (end_of_input) begin
      q_entry.has_push = in_number;
      acc_next         = '0;
      in_number_next   = 1'b0;
    end else if (is_digit) begin
      in_number_next = 1'b1;
      if (!in_number) begin
        acc_next = ACC_W'(digit);
      end else if (scaled[ACC_W+3:ACC_W] != 4'd0) begin
        acc_next = '1;
      end else begin
        acc_next = scaled[ACC_W-1:0];
      end
    end else begin
      q_entry.has_push = in_number;
      acc_next         = '0;
      in_number_next   = 1'b0;
      unique case (char_code) inside
        rsc_pkg::CH_SPACE, rsc_pkg::CH_TAB: q_entry.op = rsc_pkg::OP_NONE;
        rsc_pkg::CH_PLUS:    q_entry.op = rsc_pkg::OP_ADD;
        rsc_pkg::CH_MINUS:   q_entry.op = rsc_pkg::OP_SUB;
        rsc_pkg::CH_STAR:    q_entry.op = rsc_pkg::OP_MUL;
        rsc_pkg::CH_SLASH:   q_entry.op = rsc_pkg::OP_DIV;
        rsc_pkg::CH_NEWLINE: q_entry.op = rsc_pkg::OP_PRINT;
        default:             q_entry.op = rsc_pkg::OP_UNKNOWN;
      endcase
    end
  end

  assign q_push = accept && (q_entry.has_push || (q_entry.op != rsc_pkg::OP_NONE));

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      in_number <= 1'b0;
    end else if (accept) begin
      acc       <= acc_next;
      in_number <= in_number_next;
    end
  end

endmodule

@@ src/rsc_queue.sv @@
// Two-entry queue between the front end and the execution unit.
// Depends on rsc_pkg for the entry type.
module rsc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  rsc_pkg::entry_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output rsc_pkg::entry_t pop_data
);

  rsc_pkg::entry_t slots [2];
  logic            wptr, rptr;
  logic [1:0]      count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_data  = slots[rptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

@@ src/rsc_back.sv @@
// Execution unit of the RPN calculator: value stack memory, sequencer,
// shared 32x32 multiplier, bit-serial divider and report buffer. Depends on rsc_pkg.
module rsc_back #(
  parameter int STACK_DEPTH   = rsc_pkg::STACK_DEPTH_DEF,
  parameter int FRACTION_BITS = rsc_pkg::FRACTION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  rsc_pkg::entry_t    q_entry,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         report_kind,
  output logic signed [63:0] result_value,
  output logic [7:0]         command_code,
  output logic               last_report
);

  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam logic [127:0] HALF = (FRACTION_BITS > 0) ?
      (128'd1 << (FRACTION_BITS - 1)) : 128'd0;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PUSH = 4'd1;
  localparam logic [3:0] S_CMD  = 4'd2;
  localparam logic [3:0] S_POP1 = 4'd3;
  localparam logic [3:0] S_GET1 = 4'd4;
  localparam logic [3:0] S_POP2 = 4'd5;
  localparam logic [3:0] S_GET2 = 4'd6;
  localparam logic [3:0] S_EXEC = 4'd7;
  localparam logic [3:0] S_MUL  = 4'd8;
  localparam logic [3:0] S_MRND = 4'd9;
  localparam logic [3:0] S_DIV  = 4'd10;
  localparam logic [3:0] S_DRND = 4'd11;
  localparam logic [3:0] S_SAT  = 4'd12;
  localparam logic [3:0] S_WB   = 4'd13;
  localparam logic [3:0] S_DONE = 4'd14;
  localparam logic [3:0] S_OUT  = 4'd15;

  logic [3:0]      state;
  rsc_pkg::entry_t ent;
  logic [SPW-1:0]  sp;
  logic            stack_full, stack_empty;

  // Stack memory
  logic [63:0]     mem [STACK_DEPTH];
  logic [63:0]     rdata;
  logic            we;
  logic [AW-1:0]   waddr, raddr;
  logic [63:0]     wdata;

  // Operands and arithmetic
  logic [63:0]     p1, p2, res;
  logic            pend;
  logic            neg;
  logic [63:0]     mx, my;
  logic [63:0]     pp;
  logic [1:0]      pp_shift;
  logic [2:0]      mstep;
  logic [127:0]    acc;
  logic [127:0]    mag;
  logic [127:0]    num;
  logic [127:0]    quo;
  logic [63:0]     rem;
  logic [63:0]     dv;
  logic [6:0]      dcnt;
  logic [64:0]     rem_sh;
  logic            rem_ge;
  logic [31:0]     mul_a, mul_b;
  logic [63:0]     sum, diff, add_res, sub_res;

  // Reports
  logic [2:0]      rep_kind [2];
  logic [63:0]     rep_val  [2];
  logic [7:0]      rep_code [2];
  logic [1:0]      rep_cnt;
  logic            oidx;
  logic            out_last;

  function automatic logic [63:0] mag64(input logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  // Signed saturation of a 128-bit magnitude
  function automatic logic [63:0] sat_signed(input logic s, input logic [127:0] m);
    logic [63:0] limit;
    logic [63:0] lo;
    limit = s ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    lo    = ((m[127:64] != 64'd0) || (m[63:0] > limit)) ? limit : m[63:0];
    return s ? (64'd0 - lo) : lo;
  endfunction

  assign stack_full  = (sp == SPW'(STACK_DEPTH));
  assign stack_empty = (sp == '0);

  // Memory ports
  assign we    = ((state == S_PUSH) || (state == S_WB)) && !stack_full;
  assign waddr = sp[AW-1:0];
  assign raddr = AW'(sp - SPW'(1));
  assign wdata = (state == S_PUSH) ? ent.push_val : res;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  // Saturating add and subtract
  assign sum     = p1 + p2;
  assign add_res = ((p1[63] == p2[63]) && (sum[63] != p1[63])) ?
                   (p1[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF) : sum;
  assign diff    = p2 - p1;
  assign sub_res = ((p2[63] != p1[63]) && (diff[63] != p2[63])) ?
                   (p2[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF) : diff;

  // Partial product operand select
  assign mul_a = mstep[0] ? mx[63:32] : mx[31:0];
  assign mul_b = mstep[1] ? my[63:32] : my[31:0];

  // Divider step
  assign rem_sh = {rem, num[127]};
  assign rem_ge = rem_sh >= {1'b0, dv};

  // Output side
  assign out_valid    = (state == S_OUT);
  assign report_kind  = rep_kind[oidx];
  assign result_value = rep_val[oidx];
  assign command_code = rep_code[oidx];
  assign out_last     = ({1'b0, oidx} == (rep_cnt - 2'd1));
  assign last_report  = out_last;
  assign q_pop        = (state == S_IDLE) && q_valid;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      sp      <= '0;
      rep_cnt <= 2'd0;
      oidx    <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          rep_cnt <= 2'd0;
          oidx    <= 1'b0;
          if (q_valid) begin
            ent   <= q_entry;
            state <= q_entry.has_push ? S_PUSH : S_CMD;
          end
        end
        S_PUSH: begin
          if (!stack_full) begin
            sp <= sp + SPW'(1);
          end else begin
            rep_kind[rep_cnt[0]] <= rsc_pkg::KIND_FULL;
            rep_val[rep_cnt[0]]  <= ent.push_val;
            rep_code[rep_cnt[0]] <= 8'd0;
            rep_cnt              <= rep_cnt + 2'd1;
          end
          state <= S_CMD;
        end
        S_CMD: begin
          case (ent.op)
            rsc_pkg::OP_NONE: state <= S_DONE;
            rsc_pkg::OP_UNKNOWN: begin
              rep_kind[rep_cnt[0]] <= rsc_pkg::KIND_UNKNOWN;
              rep_val[rep_cnt[0]]  <= 64'd0;
              rep_code[rep_cnt[0]] <= ent.code;
              rep_cnt              <= rep_cnt + 2'd1;
              state                <= S_DONE;
            end
            default: state <= S_POP1;
          endcase
        end
        S_POP1, S_POP2: begin
          if (!stack_empty) begin
            sp   <= sp - SPW'(1);
            pend <= 1'b1;
          end else begin
            pend                 <= 1'b0;
            rep_kind[rep_cnt[0]] <= rsc_pkg::KIND_EMPTY;
            rep_val[rep_cnt[0]]  <= 64'd0;
            rep_code[rep_cnt[0]] <= 8'd0;
            rep_cnt              <= rep_cnt + 2'd1;
          end
          state <= (state == S_POP1) ? S_GET1 : S_GET2;
        end
        S_GET1: begin
          p1 <= pend ? rdata : 64'd0;
          if (ent.op == rsc_pkg::OP_PRINT) begin
            rep_kind[rep_cnt[0]] <= rsc_pkg::KIND_VALUE;
            rep_val[rep_cnt[0]]  <= pend ? rdata : 64'd0;
            rep_code[rep_cnt[0]] <= 8'd0;
            rep_cnt              <= rep_cnt + 2'd1;
            state                <= S_DONE;
          end else if ((ent.op == rsc_pkg::OP_DIV) && (!pend || (rdata == 64'd0))) begin
            rep_kind[rep_cnt[0]] <= rsc_pkg::KIND_ZERODIV;
            rep_val[rep_cnt[0]]  <= 64'd0;
            rep_code[rep_cnt[0]] <= 8'd0;
            rep_cnt              <= rep_cnt + 2'd1;
            state                <= S_DONE;
          end else begin
            state <= S_POP2;
          end
        end
        S_GET2: begin
          p2    <= pend ? rdata : 64'd0;
          state <= S_EXEC;
        end
        S_EXEC: begin
          neg <= p1[63] ^ p2[63];
          case (ent.op)
            rsc_pkg::OP_ADD: begin
              res   <= add_res;
              state <= S_WB;
            end
            rsc_pkg::OP_SUB: begin
              res   <= sub_res;
              state <= S_WB;
            end
            rsc_pkg::OP_MUL: begin
              mx    <= mag64(p1);
              my    <= mag64(p2);
              acc   <= '0;
              mstep <= 3'd0;
              state <= S_MUL;
            end
            default: begin
              // divide: p2 / p1
              num   <= {64'd0, mag64(p2)} << FRACTION_BITS;
              dv    <= mag64(p1);
              rem   <= '0;
              quo   <= '0;
              dcnt  <= '0;
              state <= S_DIV;
            end
          endcase
        end
        S_MUL: begin
          // one partial product per cycle, accumulated the cycle after
          if (mstep != 3'd4) begin
            pp       <= mul_a * mul_b;
            pp_shift <= 2'(mstep[0]) + 2'(mstep[1]);
          end
          if (mstep != 3'd0) begin
            acc <= acc + ({64'd0, pp} << (7'd32 * 7'(pp_shift)));
          end
          mstep <= mstep + 3'd1;
          if (mstep == 3'd4) state <= S_MRND;
        end
        S_MRND: begin
          mag   <= (acc + HALF) >> FRACTION_BITS;
          state <= S_SAT;
        end
        S_DIV: begin
          num  <= {num[126:0], 1'b0};
          rem  <= rem_ge ? 64'(rem_sh - {1'b0, dv}) : rem_sh[63:0];
          quo  <= {quo[126:0], rem_ge};
          dcnt <= dcnt + 7'd1;
          if (dcnt == 7'd127) state <= S_DRND;
        end
        S_DRND: begin
          // round to nearest, ties away from zero
          mag   <= quo + 128'((rem >= (dv - rem)) ? 1 : 0);
          state <= S_SAT;
        end
        S_SAT: begin
          res   <= sat_signed(neg, mag);
          state <= S_WB;
        end
        S_WB: begin
          if (!stack_full) begin
            sp <= sp + SPW'(1);
          end else begin
            rep_kind[rep_cnt[0]] <= rsc_pkg::KIND_FULL;
            rep_val[rep_cnt[0]]  <= res;
            rep_code[rep_cnt[0]] <= 8'd0;
            rep_cnt              <= rep_cnt + 2'd1;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          state <= (rep_cnt != 2'd0) ? S_OUT : S_IDLE;
        end
        S_OUT: begin
          if (!out_stall) begin
            if (out_last) state <= S_IDLE;
            else          oidx  <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ src/rpn_stack_calculator.sv @@
// RPN stack calculator top level: front end, entry queue and execution unit.
// Depends on rsc_pkg, rsc_front, rsc_queue and rsc_back.
//
// Input channel: one character per transfer (char_code, end_of_input) under
// in_valid / in_stall. Digits, and blanks or end-of-input without a pending
// number, are absorbed by the front end with no queue entry; other characters
// become one queue entry. The two-entry queue lets the front end keep taking
// characters while the execution unit works.
// Output channel: reports (report_kind, result_value, command_code,
// last_report) under out_valid / out_stall; an item gives at most two,
// last_report marks the final one. A held report keeps its fields stable.
// In the execution unit, multiply forms four 32x32 partial products on one
// multiplier, and divide produces one quotient bit per cycle over 128 bits of
// dividend. Each report then takes one transfer.
// Stack accesses use one memory with a write port and a registered read.
// Reset (rst, synchronous) empties the stack and queue and clears any
// pending number; stack contents are not cleared. While the receiver
// stalls, the execution unit holds and the queue fills, then in_stall rises.
module rpn_stack_calculator #(
  parameter int STACK_DEPTH   = rsc_pkg::STACK_DEPTH_DEF,
  parameter int FRACTION_BITS = rsc_pkg::FRACTION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         char_code,
  input  logic               end_of_input,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         report_kind,
  output logic signed [63:0] result_value,
  output logic [7:0]         command_code,
  output logic               last_report
);

  rsc_pkg::entry_t fe_entry, q_head;
  logic            fe_push, q_full, q_not_empty, q_pop;

  rsc_front #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .char_code    (char_code),
    .end_of_input (end_of_input),
    .q_full       (q_full),
    .q_push       (fe_push),
    .q_entry      (fe_entry)
  );

  rsc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (fe_push),
    .push_data (fe_entry),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_head)
  );

  rsc_back #(
    .STACK_DEPTH   (STACK_DEPTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_not_empty),
    .q_entry      (q_head),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .report_kind  (report_kind),
    .result_value (result_value),
    .command_code (command_code),
    .last_report  (last_report)
  );

endmodule
